// ----- src/pngcp_pkg.sv -----
// Shared types, constants and helpers for the PNG chunk stream parser.
// No dependencies; imported by every module in src except pngcp_in_reg.
`timescale 1ns / 1ps
`default_nettype none

package pngcp_pkg;

  typedef enum logic [1:0] {
    PH_SIG  = 2'd0,
    PH_HDR  = 2'd1,
    PH_DATA = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FORMAT  = 3'd1;
  localparam logic [2:0] ST_CORRUPT = 3'd2;
  localparam logic [2:0] ST_HEADER  = 3'd3;
  localparam logic [2:0] ST_DIMS    = 3'd4;
  localparam logic [2:0] ST_UNSUP   = 3'd5;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] IHDR_LEN  = 32'd13;

  localparam int TDATA_W = 80;
  localparam int TUSER_W = 2;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [2:0]  channels;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

  // Bytes per pixel; zero for any color type or depth this parser rejects.
  function automatic logic [2:0] channel_count(input logic [7:0] color,
                                               input logic [7:0] depth);
    logic [2:0] ch;
    case (color)
      8'd0:    ch = 3'd1;
      8'd2:    ch = 3'd3;
      8'd4:    ch = 3'd2;
      8'd6:    ch = 3'd4;
      default: ch = 3'd0;
    endcase
    if (depth != 8'd8) begin
      ch = 3'd0;
    end
    return ch;
  endfunction

  function automatic logic [2:0] end_status(input logic hdr_ok, input logic idat_ok,
                                            input logic [2:0] ch);
    logic [2:0] st;
    if (!hdr_ok || !idat_ok) begin
      st = ST_CORRUPT;
    end else if (ch == 3'd0) begin
      st = ST_UNSUP;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

`default_nettype wire

// ----- src/png_chunk_stream_parser_core.sv -----
// A byte is held in the input register, decoded by the parser and its result
// held in the result register. Throughput: one byte per cycle; the input
// register and the result register advance together, so the only limit is
// the master-side tready. Bytes that cause no result (signature, chunk
// headers, CRC, non-IDAT data) produce no transaction. Synchronous active-high
// rst clears both register stages and returns the parser to the signature phase.
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_stream_parser_core
  import pngcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] byte_in
  input  wire logic               s_axis_tlast,   // last_in
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                                  // [42:11] image_width,
                                                  // [74:43] image_height,
                                                  // [77:75] channels, [79:78] zero
  output logic [TUSER_W-1:0]      m_axis_tuser    // [0] payload_valid, [1] done_res
);

  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       space;
  logic       step;
  logic       res_valid;
  result_t    res;

  assign step = q_valid && space;

  pngcp_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_byte  (s_axis_tdata),
    .s_last  (s_axis_tlast),
    .take    (space),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_last  (q_last)
  );

  pngcp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (q_byte),
    .last_in   (q_last),
    .res_valid (res_valid),
    .res       (res)
  );

  pngcp_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (step && res_valid),
    .res     (res),
    .space   (space),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_user  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("result is neither or both payload and final");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[TDATA_W-1:8] == '0))
    else $error("payload transaction carries nonzero status fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[10:8] <= ST_UNSUP))
    else $error("final status out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !step)
    else $error("parser stepped while result register is stalled");
`endif

endmodule

`default_nettype wire

// ----- src/pngcp_in_reg.sv -----
// Input register stage: captures one byte transaction from the slave side.
// Depends on no package or other module.
`timescale 1ns / 1ps
`default_nettype none

module pngcp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  input  wire logic [7:0] s_byte,
  input  wire logic       s_last,
  input  wire logic       take,
  output logic            q_valid,
  output logic [7:0]      q_byte,
  output logic            q_last
);

  logic accept;

  assign s_ready = !q_valid || take;
  assign accept  = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_byte <= s_byte;
      q_last <= s_last;
    end
  end

endmodule

`default_nettype wire

// ----- src/pngcp_parser.sv -----
// Chunk framing state and per-byte decision logic of the PNG parser.
// Uses pngcp_pkg for phases, status codes, chunk types and helpers.
`timescale 1ns / 1ps
`default_nettype none

module pngcp_parser
  import pngcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_in,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic        header_seen, header_seen_next;
  logic        idat_seen, idat_seen_next;
  logic [31:0] width_reg, width_reg_next;
  logic [31:0] height_reg, height_reg_next;
  logic [7:0]  color_kind, color_kind_next;
  logic [7:0]  sample_depth, sample_depth_next;
  logic [2:0]  header_flags, header_flags_next;
  logic        finished, finished_next;

  logic        final_hit;
  logic [2:0]  final_status;
  logic        pay;
  logic [31:0] fc_inc;
  logic [2:0]  ch_now;
  logic [31:0] out_width;
  logic [31:0] out_height;

  assign fc_inc = field_count + 32'd1;

  // Next state and final status for the byte in the input register.
  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    chunk_length_next = chunk_length;
    chunk_type_next   = chunk_type;
    header_seen_next  = header_seen;
    idat_seen_next    = idat_seen;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    color_kind_next   = color_kind;
    sample_depth_next = sample_depth;
    header_flags_next = header_flags;
    finished_next     = finished;
    final_hit         = 1'b0;
    final_status      = ST_OK;
    pay               = 1'b0;
    ch_now            = 3'd0;
    out_width         = 32'd0;
    out_height        = 32'd0;

    if (step) begin
      if (finished) begin
        // swallow the rest of the file; the last byte re-arms
        if (last_in) begin
          finished_next = 1'b0;
        end
      end else begin
        case (phase)
          PH_SIG: begin
            if (byte_in != sig_byte(field_count[2:0])) begin
              final_hit    = 1'b1;
              final_status = ST_FORMAT;
            end else if (field_count[2:0] == 3'd7) begin
              field_count_next = 32'd0;
              phase_next       = PH_HDR;
            end else begin
              field_count_next = fc_inc;
            end
          end
          PH_HDR: begin
            if (!field_count[2]) begin
              chunk_length_next = {chunk_length[23:0], byte_in};
            end else begin
              chunk_type_next = {chunk_type[23:0], byte_in};
            end
            if (field_count[2:0] == 3'd7) begin
              field_count_next = 32'd0;
              if (chunk_type_next == TYPE_IHDR) begin
                if (chunk_length != IHDR_LEN) begin
                  final_hit    = 1'b1;
                  final_status = ST_HEADER;
                end else begin
                  phase_next = PH_DATA;
                end
              end else if (chunk_type_next == TYPE_IDAT) begin
                if (!header_seen) begin
                  final_hit    = 1'b1;
                  final_status = ST_CORRUPT;
                end else begin
                  phase_next = (chunk_length != 32'd0) ? PH_DATA : PH_CRC;
                end
              end else if (chunk_type_next == TYPE_IEND) begin
                final_hit    = 1'b1;
                final_status = end_status(header_seen, idat_seen,
                                          channel_count(color_kind, sample_depth));
              end else begin
                phase_next = (chunk_length != 32'd0) ? PH_DATA : PH_CRC;
              end
            end else begin
              field_count_next = fc_inc;
            end
          end
          PH_DATA: begin
            if (chunk_type == TYPE_IHDR) begin
              case (field_count[3:0]) inside
                [4'd0:4'd3]: width_reg_next  = {width_reg[23:0], byte_in};
                [4'd4:4'd7]: height_reg_next = {height_reg[23:0], byte_in};
                4'd8:        sample_depth_next = byte_in;
                4'd9:        color_kind_next   = byte_in;
                4'd10:       header_flags_next[0] = (byte_in != 8'd0);
                4'd11:       header_flags_next[1] = (byte_in != 8'd0);
                4'd12:       header_flags_next[2] = (byte_in != 8'd0);
                default:     ;
              endcase
            end else if (chunk_type == TYPE_IDAT) begin
              pay            = 1'b1;
              idat_seen_next = 1'b1;
            end
            if (fc_inc >= chunk_length) begin
              field_count_next = 32'd0;
              phase_next       = PH_CRC;
              if (chunk_type == TYPE_IHDR) begin
                if (width_reg_next == 32'd0 || height_reg_next == 32'd0) begin
                  final_hit    = 1'b1;
                  final_status = ST_DIMS;
                end else if (header_flags_next != 3'd0) begin
                  final_hit    = 1'b1;
                  final_status = ST_UNSUP;
                end else begin
                  header_seen_next = 1'b1;
                end
              end
            end else begin
              field_count_next = fc_inc;
            end
          end
          PH_CRC: begin
            // CRC bytes are skipped unchecked
            if (field_count[1:0] == 2'd3) begin
              field_count_next = 32'd0;
              phase_next       = PH_HDR;
            end else begin
              field_count_next = fc_inc;
            end
          end
          default: ;
        endcase

        ch_now = channel_count(color_kind_next, sample_depth_next);

        if (!final_hit && last_in) begin
          final_hit = 1'b1;
          if (phase_next == PH_HDR && field_count_next == 32'd0) begin
            final_status = end_status(header_seen_next, idat_seen_next, ch_now);
          end else if (phase_next == PH_SIG) begin
            final_status = ST_FORMAT;
          end else begin
            final_status = ST_CORRUPT;
          end
        end

        out_width  = width_reg_next;
        out_height = height_reg_next;

        if (final_hit) begin
          // re-arm for the next file
          phase_next        = PH_SIG;
          field_count_next  = 32'd0;
          chunk_length_next = 32'd0;
          chunk_type_next   = 32'd0;
          header_seen_next  = 1'b0;
          idat_seen_next    = 1'b0;
          width_reg_next    = 32'd0;
          height_reg_next   = 32'd0;
          color_kind_next   = 8'd0;
          sample_depth_next = 8'd0;
          header_flags_next = 3'd0;
          finished_next     = !last_in;
        end
      end
    end
  end

  // Result formatting: a final result drops any payload byte.
  always_comb begin
    res       = '0;
    res_valid = final_hit || pay;
    if (final_hit) begin
      res.done_res     = 1'b1;
      res.status       = final_status;
      res.image_width  = out_width;
      res.image_height = out_height;
      res.channels     = (final_status == ST_OK) ? ch_now : 3'd0;
    end else if (pay) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      field_count  <= 32'd0;
      chunk_length <= 32'd0;
      chunk_type   <= 32'd0;
      header_seen  <= 1'b0;
      idat_seen    <= 1'b0;
      width_reg    <= 32'd0;
      height_reg   <= 32'd0;
      color_kind   <= 8'd0;
      sample_depth <= 8'd0;
      header_flags <= 3'd0;
      finished     <= 1'b0;
    end else begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      chunk_length <= chunk_length_next;
      chunk_type   <= chunk_type_next;
      header_seen  <= header_seen_next;
      idat_seen    <= idat_seen_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      color_kind   <= color_kind_next;
      sample_depth <= sample_depth_next;
      header_flags <= header_flags_next;
      finished     <= finished_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/pngcp_out_reg.sv -----
// Result register: holds one result transaction for the master side.
// Uses pngcp_pkg for the result struct and bus widths.
`timescale 1ns / 1ps
`default_nettype none

module pngcp_out_reg
  import pngcp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire result_t      res,
  output logic              space,
  output logic              m_valid,
  input  wire logic         m_ready,
  output logic [TDATA_W-1:0] m_data,
  output logic [TUSER_W-1:0] m_user
);

  result_t held;

  // the slot frees up in the same cycle its transaction completes
  assign space = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_data = {2'b00, held.channels, held.image_height, held.image_width,
                   held.status, held.payload_byte};
  assign m_user = {held.done_res, held.payload_valid};

endmodule

`default_nettype wire
